[rtl/tmse_pkg.sv]
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types, codes and helpers for the tape machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

   // field widths of the item channels
   localparam int ACTION_W = 2;
   localparam int STATE_W  = 4;
   localparam int SYMBOL_W = 8;
   localparam int ADDR_W   = 10;
   localparam int STATUS_W = 2;

   // item actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_STEP    = 2'd3
   } action_type;

   // fixed machine states
   localparam logic [STATE_W-1:0] ST_START  = 4'd0;
   localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd1;
   localparam logic [STATE_W-1:0] ST_REJECT = 4'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DUP_RULE = 2'd3;

   // one rule table entry
   typedef struct packed {
      logic                valid;
      logic [STATE_W-1:0]  next;
      logic [SYMBOL_W-1:0] wsym;
      logic                right;
   } rule_entry_type;

   localparam int RULE_W = $bits(rule_entry_type);

   // status reported for a machine state
   function automatic logic [STATUS_W-1:0] status_of(input logic [STATE_W-1:0] st);
      logic [STATUS_W-1:0] res;
      res = STAT_OK;
      if (st == ST_ACCEPT) res = STAT_ACCEPTED;
      else if (st == ST_REJECT) res = STAT_REJECTED;
      return res;
   endfunction

endpackage

[rtl/tmse_ram.sv]
// ----------------------------------------------------------------------------
// tmse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tmse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tmse_clear.sv]
// ----------------------------------------------------------------------------
// tmse_clear
// Post-reset sweep counter: walks every address once while busy is high.
// ----------------------------------------------------------------------------
module tmse_clear #(
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   output logic          busy,
   output logic [AW-1:0] addr
);

   logic          busy_ff;
   logic [AW-1:0] addr_ff;

   // one address per cycle until the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else if (busy_ff) begin
         if (addr_ff == AW'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

[rtl/turing_machine_step_engine_unit.sv]
// ----------------------------------------------------------------------------
// turing_machine_step_engine_unit
// Single-tape state machine executor with rule memory, tape memory and head.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one action per item (load rule, write tape cell, restart,
//   step); rsp_* returns exactly one result item per request, in order.
//   Both channels use valid/ready; a transfer happens when both are high.
// Sequence (accept to result valid, output register free):
//   load rule via the load phase, tape write and restart via the done phase,
//   step via a tape read, then a rule read addressed by the symbol read; the
//   write back and the result share the last edge. A step in accept or reject
//   goes via the done phase. Flow: one item at a time; the next item is
//   accepted at the edge after the previous result is registered, and a step
//   is slowed by the chained synchronous reads of the tape and rule memories.
// Reset: state goes to start, head to cell 0. A clearing sweep then blanks
//   the tape and invalidates all rules, one address per cycle, over
//   max(TAPE_CELLS, NUM_STATES*256) addresses (4096 at defaults); req_ready is
//   low during the sweep.
// Stall: the result sits in an output register; while rsp_ready is low a
//   new item may still be accepted and worked on, and it waits at its last
//   stage until the output register frees up.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_unit #(
   parameter int NUM_STATES = 16,
   parameter int TAPE_CELLS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tmse_pkg::ACTION_W-1:0]      req_action,
   input  logic [tmse_pkg::STATE_W-1:0]       req_state_id,
   input  logic [tmse_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic [tmse_pkg::STATE_W-1:0]       req_next_state_id,
   input  logic [tmse_pkg::SYMBOL_W-1:0]      req_write_symbol,
   input  logic                               req_move_right,
   input  logic [tmse_pkg::ADDR_W-1:0]        req_tape_address,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tmse_pkg::STATE_W-1:0]       rsp_machine_state,
   output logic [tmse_pkg::ADDR_W-1:0]        rsp_head_position,
   output logic [tmse_pkg::SYMBOL_W-1:0]      rsp_symbol_seen,
   output logic [tmse_pkg::STATUS_W-1:0]      rsp_status
);

   import tmse_pkg::*;

   localparam int TAW       = $clog2(TAPE_CELLS);
   localparam int RULE_CNT  = NUM_STATES * 256;
   localparam int RAW       = $clog2(RULE_CNT);
   localparam int CLR_DEPTH = (TAPE_CELLS > RULE_CNT) ? TAPE_CELLS : RULE_CNT;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LOAD,
      PH_FETCH,
      PH_APPLY,
      PH_DONE
   } phase_type;

   // registers
   phase_type           phase_ff, phase_in;
   action_type          action_ff;
   logic [STATE_W-1:0]  sid_ff;
   logic [SYMBOL_W-1:0] sym_ff;
   logic [STATE_W-1:0]  nsid_ff;
   logic [SYMBOL_W-1:0] wsym_ff;
   logic                right_ff;
   logic [STATE_W-1:0]  cur_ff;
   logic [TAW-1:0]      head_ff;
   logic [SYMBOL_W-1:0] seen_ff, seen_in;
   logic                rsp_valid_ff;
   logic [STATE_W-1:0]  rsp_state_ff;
   logic [ADDR_W-1:0]   rsp_head_ff;
   logic [SYMBOL_W-1:0] rsp_seen_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // memory ports
   logic                tape_we, tape_re;
   logic [TAW-1:0]      tape_wa, tape_ra;
   logic [SYMBOL_W-1:0] tape_wd, tape_rd;
   logic                rule_we, rule_re;
   logic [RAW-1:0]      rule_wa, rule_ra;
   rule_entry_type      rule_wd, rule_rd;

   // fsm side of the memory writes
   logic                f_tape_we;
   logic [TAW-1:0]      f_tape_wa;
   logic [SYMBOL_W-1:0] f_tape_wd;
   logic                f_rule_we;

   // result of the item being finished
   logic                fire;
   logic [STATE_W-1:0]  res_state;
   logic [TAW-1:0]      res_head;
   logic [SYMBOL_W-1:0] res_seen;
   logic                res_dup;

   logic                clr_busy;
   logic [CLR_AW-1:0]   clr_addr;
   logic                accept, out_free, halted, hit, load_ok;
   action_type          req_act;

   // ------------------------------------------------------------------------
   // clearing sweep and memories
   // ------------------------------------------------------------------------
   tmse_clear #(.DEPTH(CLR_DEPTH)) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   tmse_ram #(.WIDTH(SYMBOL_W), .DEPTH(TAPE_CELLS)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_wa),
      .wr_data (tape_wd),
      .rd_en   (tape_re),
      .rd_addr (tape_ra),
      .rd_data (tape_rd)
   );

   tmse_ram #(.WIDTH(RULE_W), .DEPTH(RULE_CNT)) u_rules (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_wa),
      .wr_data (rule_wd),
      .rd_en   (rule_re),
      .rd_addr (rule_ra),
      .rd_data (rule_rd)
   );

   // sweep owns the write ports until it finishes
   always_comb begin
      if (clr_busy) begin
         tape_we = (32'(clr_addr) < TAPE_CELLS);
         tape_wa = TAW'(clr_addr);
         tape_wd = '0;
         rule_we = (32'(clr_addr) < RULE_CNT);
         rule_wa = RAW'(clr_addr);
         rule_wd = '0;
      end else begin
         tape_we = f_tape_we;
         tape_wa = f_tape_wa;
         tape_wd = f_tape_wd;
         rule_we = f_rule_we;
         rule_wa = RAW'({sid_ff, sym_ff});
         rule_wd = '{valid: 1'b1, next: nsid_ff, wsym: wsym_ff, right: right_ff};
      end
   end

   // ------------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------------
   assign req_ready = (phase_ff == PH_IDLE) && !clr_busy;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_act   = action_type'(req_action);
   assign halted    = (cur_ff == ST_ACCEPT) || (cur_ff == ST_REJECT);
   assign hit       = rule_rd.valid && (32'(cur_ff) < NUM_STATES);
   assign load_ok   = (32'(sid_ff) < NUM_STATES) && (32'(nsid_ff) < NUM_STATES);

   // ------------------------------------------------------------------------
   // sequencer next state, memory requests and result
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      f_tape_we = 1'b0;
      f_tape_wa = head_ff;
      f_tape_wd = wsym_ff;
      f_rule_we = 1'b0;
      tape_re   = 1'b0;
      tape_ra   = head_ff;
      rule_re   = 1'b0;
      rule_ra   = RAW'({req_state_id, req_symbol});
      fire      = 1'b0;
      res_state = cur_ff;
      res_head  = head_ff;
      res_seen  = '0;
      res_dup   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               unique case (req_act)
                  ACT_LOAD: begin
                     rule_re  = 1'b1;
                     phase_in = PH_LOAD;
                  end
                  ACT_WRITE: begin
                     f_tape_we = (32'(req_tape_address) < TAPE_CELLS);
                     f_tape_wa = TAW'(req_tape_address);
                     f_tape_wd = req_symbol;
                     phase_in  = PH_DONE;
                  end
                  ACT_RESTART: begin
                     phase_in = PH_DONE;
                  end
                  ACT_STEP: begin
                     if (halted) begin
                        phase_in = PH_DONE;
                     end else begin
                        tape_re  = 1'b1;
                        phase_in = PH_FETCH;
                     end
                  end
               endcase
            end
         end
         PH_LOAD: begin
            if (out_free) begin
               fire      = 1'b1;
               res_dup   = load_ok && rule_rd.valid;
               f_rule_we = load_ok && !rule_rd.valid;
               phase_in  = PH_IDLE;
            end
         end
         PH_FETCH: begin
            // symbol under the head selects the rule row
            seen_in  = tape_rd;
            rule_re  = 1'b1;
            rule_ra  = RAW'({cur_ff, tape_rd});
            phase_in = PH_APPLY;
         end
         PH_APPLY: begin
            if (out_free) begin
               fire     = 1'b1;
               res_seen = seen_ff;
               phase_in = PH_IDLE;
               if (hit) begin
                  f_tape_we = 1'b1;
                  f_tape_wd = rule_rd.wsym;
                  res_state = rule_rd.next;
                  if (rule_rd.right) begin
                     if (head_ff != TAW'(TAPE_CELLS - 1)) res_head = head_ff + 1'b1;
                  end else begin
                     if (head_ff != '0) res_head = head_ff - 1'b1;
                  end
               end else begin
                  res_state = ST_REJECT;
               end
            end
         end
         PH_DONE: begin
            if (out_free) begin
               fire     = 1'b1;
               phase_in = PH_IDLE;
               if (action_ff == ACT_RESTART) begin
                  res_state = ST_START;
                  res_head  = '0;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // state and registered outputs
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cur_ff       <= ST_START;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (fire) begin
            cur_ff       <= res_state;
            head_ff      <= res_head;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload, no reset
      seen_ff <= seen_in;
      if (accept) begin
         action_ff <= req_act;
         sid_ff    <= req_state_id;
         sym_ff    <= req_symbol;
         nsid_ff   <= req_next_state_id;
         wsym_ff   <= req_write_symbol;
         right_ff  <= req_move_right;
      end
      if (fire) begin
         rsp_state_ff  <= res_state;
         rsp_head_ff   <= ADDR_W'(res_head);
         rsp_seen_ff   <= res_seen;
         rsp_status_ff <= res_dup ? STAT_DUP_RULE : status_of(res_state);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_machine_state = rsp_state_ff;
   assign rsp_head_position = rsp_head_ff;
   assign rsp_symbol_seen   = rsp_seen_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[tb/sv/turing_machine_step_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// turing_machine_step_engine_unit_tb
// Self-checking bench for the tape machine step engine. A mirror of the rule
// table, tape, head and machine state tracks every accepted request and
// queues the result it should produce; each returned result is compared
// field by field, in order. Stimulus is a short directed walk through the
// corner cases, a full right sweep to the last tape cell, then random
// programs (restart, tape setup, rule loads, steps to halt or a limit) mixed
// with random noise items, under three idling profiles on both channels.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_unit_tb;
   import tmse_pkg::*;

   localparam int TAPE_DEPTH    = 1024;
   localparam int RANDOM_ITEMS  = 450;
   localparam int SWEEP_STEPS   = 1026;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 20;

   // one request item
   typedef struct {
      action_type          act;
      logic [STATE_W-1:0]  state_id;
      logic [SYMBOL_W-1:0] symbol;
      logic [STATE_W-1:0]  next_sid;
      logic [SYMBOL_W-1:0] wsym;
      logic                right;
      logic [ADDR_W-1:0]   addr;
   } machine_request_type;

   // one result item
   typedef struct packed {
      logic [STATE_W-1:0]  mstate;
      logic [ADDR_W-1:0]   head;
      logic [SYMBOL_W-1:0] seen;
      logic [STATUS_W-1:0] status;
   } machine_outcome_type;

   // mirror of the machine plus the queue of outcomes still owed
   class tape_machine_mirror;
      logic [SYMBOL_W-1:0] tape [TAPE_DEPTH];
      rule_entry_type      rules [1 << (STATE_W + SYMBOL_W)];
      logic [STATE_W-1:0]  cur_state;
      logic [ADDR_W-1:0]   head;
      machine_outcome_type owed[$];
      int                  mismatches;

      function new();
         foreach (tape[i]) tape[i] = '0;
         foreach (rules[i]) rules[i] = '0;
         cur_state  = ST_START;
         head       = '0;
         mismatches = 0;
      endfunction

      function bit halted();
         return cur_state == ST_ACCEPT || cur_state == ST_REJECT;
      endfunction

      // advance the mirror by one accepted request, queue its outcome
      function void apply_action(machine_request_type rq);
         logic [STATE_W+SYMBOL_W-1:0] idx;
         logic [SYMBOL_W-1:0]         seen;
         bit                          dup;
         machine_outcome_type         res;
         seen = '0;
         dup  = 1'b0;
         case (rq.act)
            ACT_LOAD: begin
               idx = {rq.state_id, rq.symbol};
               if (rules[idx].valid) dup = 1'b1;
               else rules[idx] = '{1'b1, rq.next_sid, rq.wsym, rq.right};
            end
            ACT_WRITE: tape[rq.addr] = rq.symbol;
            ACT_RESTART: begin
               cur_state = ST_START;
               head      = '0;
            end
            default: begin
               if (!halted()) begin
                  seen = tape[head];
                  idx  = {cur_state, seen};
                  if (rules[idx].valid) begin
                     tape[head] = rules[idx].wsym;
                     cur_state  = rules[idx].next;
                     if (rules[idx].right) begin
                        if (head != TAPE_DEPTH - 1) head++;
                     end else begin
                        if (head != 0) head--;
                     end
                  end else begin
                     cur_state = ST_REJECT;
                  end
               end
            end
         endcase
         res.mstate = cur_state;
         res.head   = head;
         res.seen   = seen;
         if (dup) res.status = STAT_DUP_RULE;
         else if (cur_state == ST_ACCEPT) res.status = STAT_ACCEPTED;
         else if (cur_state == ST_REJECT) res.status = STAT_REJECTED;
         else res.status = STAT_OK;
         owed.push_back(res);
      endfunction

      function void compare_field(string name, int exp_val, int got_val);
         if (exp_val != got_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, got_val);
         end
      endfunction

      // match a returned result against the oldest owed outcome
      function void compare_outcome(machine_outcome_type got);
         machine_outcome_type exp;
         if (owed.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %p",
                     $time, got);
            return;
         end
         exp = owed.pop_front();
         compare_field("machine_state", exp.mstate, got.mstate);
         compare_field("head_position", exp.head, got.head);
         compare_field("symbol_seen", exp.seen, got.seen);
         compare_field("status", exp.status, got.status);
      endfunction
   endclass

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action        = '0;
   logic [STATE_W-1:0]  req_state_id      = '0;
   logic [SYMBOL_W-1:0] req_symbol        = '0;
   logic [STATE_W-1:0]  req_next_state_id = '0;
   logic [SYMBOL_W-1:0] req_write_symbol  = '0;
   logic                req_move_right    = 1'b0;
   logic [ADDR_W-1:0]   req_tape_address  = '0;
   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic [STATE_W-1:0]  rsp_machine_state;
   logic [ADDR_W-1:0]   rsp_head_position;
   logic [SYMBOL_W-1:0] rsp_symbol_seen;
   logic [STATUS_W-1:0] rsp_status;

   tape_machine_mirror mirror = new();
   int send_idle_pct = 33;
   int recv_idle_pct = 64;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   turing_machine_step_engine_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_state_id      (req_state_id),
      .req_symbol        (req_symbol),
      .req_next_state_id (req_next_state_id),
      .req_write_symbol  (req_write_symbol),
      .req_move_right    (req_move_right),
      .req_tape_address  (req_tape_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_machine_state (rsp_machine_state),
      .rsp_head_position (rsp_head_position),
      .rsp_symbol_seen   (rsp_symbol_seen),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: check accepted results, then draw the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.compare_outcome('{rsp_machine_state, rsp_head_position,
                                  rsp_symbol_seen, rsp_status});
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog: cycles without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // request with every field random
   function automatic machine_request_type any_request();
      machine_request_type rq;
      rq.act      = action_type'($urandom_range(0, 3));
      rq.state_id = STATE_W'($urandom);
      rq.symbol   = SYMBOL_W'($urandom);
      rq.next_sid = STATE_W'($urandom);
      rq.wsym     = SYMBOL_W'($urandom);
      rq.right    = 1'($urandom);
      rq.addr     = ADDR_W'($urandom);
      return rq;
   endfunction

   function automatic machine_request_type load_rule(
      logic [STATE_W-1:0] sid, logic [SYMBOL_W-1:0] sym,
      logic [STATE_W-1:0] nsid, logic [SYMBOL_W-1:0] wsym, logic right);
      machine_request_type rq;
      rq          = any_request();
      rq.act      = ACT_LOAD;
      rq.state_id = sid;
      rq.symbol   = sym;
      rq.next_sid = nsid;
      rq.wsym     = wsym;
      rq.right    = right;
      return rq;
   endfunction

   function automatic machine_request_type write_cell(logic [ADDR_W-1:0] addr,
                                                      logic [SYMBOL_W-1:0] sym);
      machine_request_type rq;
      rq        = any_request();
      rq.act    = ACT_WRITE;
      rq.addr   = addr;
      rq.symbol = sym;
      return rq;
   endfunction

   function automatic machine_request_type bare_action(action_type act);
      machine_request_type rq;
      rq     = any_request();
      rq.act = act;
      return rq;
   endfunction

   // present one item, optionally after a random gap, and wait for accept
   task automatic send_item(input machine_request_type rq);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_action        <= rq.act;
      req_state_id      <= rq.state_id;
      req_symbol        <= rq.symbol;
      req_next_state_id <= rq.next_sid;
      req_write_symbol  <= rq.wsym;
      req_move_right    <= rq.right;
      req_tape_address  <= rq.addr;
      do @(posedge clock); while (!req_ready);
      mirror.apply_action(rq);
      items_sent++;
   endtask

   // hold off new items until every owed result has returned
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.owed.size() != 0);
   endtask

   // random program: restart, seed the tape, load rules, run until halt or a step limit
   task automatic run_program();
      logic [SYMBOL_W-1:0] alpha [4];
      logic [STATE_W-1:0]  states [3];
      logic [STATE_W-1:0]  nsid;
      int                  n_sym;
      int                  n_st;
      int                  pick;
      n_sym = $urandom_range(2, 4);
      n_st  = $urandom_range(1, 3);
      for (int i = 0; i < 4; i++)
         alpha[i] = (i == 0 && $urandom_range(0, 1)) ? 8'h00 : SYMBOL_W'($urandom);
      states[0] = ST_START;
      for (int i = 1; i < 3; i++) states[i] = STATE_W'($urandom_range(3, 15));

      send_item(bare_action(ACT_RESTART));
      repeat ($urandom_range(0, 6))
         send_item(write_cell(ADDR_W'($urandom_range(0, 8)),
                              alpha[$urandom_range(0, n_sym - 1)]));
      for (int s = 0; s < n_st; s++) begin
         for (int a = 0; a < n_sym; a++) begin
            if ($urandom_range(0, 9) < 8) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) nsid = states[$urandom_range(0, n_st - 1)];
               else if (pick < 8) nsid = ST_ACCEPT;
               else if (pick == 8) nsid = ST_REJECT;
               else nsid = STATE_W'($urandom);
               send_item(load_rule(states[s], alpha[a], nsid,
                                   alpha[$urandom_range(0, n_sym - 1)], 1'($urandom)));
            end
         end
      end
      for (int i = $urandom_range(4, 30); i > 0; i--) begin
         send_item(bare_action(ACT_STEP));
         if (mirror.halted()) break;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, halting, duplicates, clamping at cell 0
      send_item(bare_action(ACT_STEP));
      send_item(bare_action(ACT_STEP));
      send_item(bare_action(ACT_RESTART));
      send_item(write_cell(10'h3FF, 8'hFF));
      send_item(write_cell(10'h000, 8'hAA));
      send_item(load_rule(4'd0, 8'hAA, 4'd15, 8'h00, 1'b1));
      send_item(load_rule(4'd0, 8'hAA, 4'd4, 8'h33, 1'b0));
      send_item(load_rule(4'd15, 8'h00, 4'd15, 8'h00, 1'b1));
      send_item(load_rule(4'd15, 8'hFF, 4'd15, 8'hFF, 1'b1));
      send_item(load_rule(4'd0, 8'h55, 4'd3, 8'h01, 1'b0));
      send_item(load_rule(4'd3, 8'h01, ST_ACCEPT, 8'h80, 1'b1));
      send_item(load_rule(ST_ACCEPT, 8'h00, 4'd15, 8'hFF, 1'b1));
      send_item(load_rule(ST_REJECT, 8'h00, 4'd0, 8'h11, 1'b0));
      send_item(write_cell(10'h000, 8'h55));
      send_item(bare_action(ACT_RESTART));
      send_item(bare_action(ACT_STEP));
      send_item(bare_action(ACT_STEP));
      send_item(bare_action(ACT_STEP));
      send_item(write_cell(10'h000, 8'hAA));
      send_item(bare_action(ACT_RESTART));

      // full right sweep, ending with clamped steps at the last cell
      repeat (SWEEP_STEPS) send_item(bare_action(ACT_STEP));
      drain_results();

      // random programs with noise between them, three idling profiles
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            if (send_idle_pct == 33) drain_results();
            send_idle_pct = 64;
            recv_idle_pct = 33;
         end
         run_program();
         repeat ($urandom_range(0, 4)) send_item(any_request());
      end

      // wind down
      req_valid <= 1'b0;
      while (mirror.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.owed.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
